/* rtl/qec_pkg.sv */
`timescale 1ns / 1ps
// Package for the quadrature encoder counter: shared types, register
// indexes and reset values. No dependencies.
package qec_pkg;

  typedef logic [1:0] phase_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_SET_CW,
    ACT_SET_CCW,
    ACT_DEC,
    ACT_INC
  } action_t;

  // Decoder step handed from the phase table to the count and state logic
  typedef struct packed {
    phase_t  next_phase;
    action_t action;
  } qec_step_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_STEP_SIZE = 2'd0,
    REG_MIN_COUNT = 2'd1,
    REG_MAX_COUNT = 2'd2
  } reg_index_t;

  localparam int CfgDataWidth = 16;

  localparam logic [7:0]  STEP_SIZE_RESET = 8'd1;
  localparam logic [14:0] MIN_COUNT_RESET = 15'd0;
  localparam logic [14:0] MAX_COUNT_RESET = 15'd500;

  localparam phase_t PHASE_RESET = 2'd0;

endpackage

/* rtl/qec_if.sv */
`timescale 1ns / 1ps
// Channel interfaces of the quadrature encoder counter: input items,
// result items and configuration writes. Depends on qec_pkg.
interface qec_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic               line_sel;
  logic               rising;
  logic signed [15:0] load_value;

  modport source (output valid, output op, output line_sel, output rising,
                  output load_value, input ready);
  modport sink   (input valid, input op, input line_sel, input rising,
                  input load_value, output ready);
endinterface

interface qec_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] count;
  qec_pkg::phase_t    phase;

  modport source (output valid, output count, output phase, input ready);
  modport sink   (input valid, input count, input phase, output ready);
endinterface

interface qec_cfg_if;
  logic                              valid;
  logic                              ready;
  qec_pkg::reg_index_t               index;
  logic [qec_pkg::CfgDataWidth-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/qec_decode.sv */
`timescale 1ns / 1ps
// Phase table of the quadrature decoder: next phase and action for one
// edge event. Depends on qec_pkg.
module qec_decode (
  input  qec_pkg::phase_t    phase,
  input  logic               line_sel,
  input  logic               rising,
  output qec_pkg::qec_step_t step
);
  import qec_pkg::*;

  always_comb begin
    step.next_phase = phase;
    step.action     = ACT_NONE;
    case (phase)
      2'd0: begin
        if (!rising) begin
          if (!line_sel) begin
            step.next_phase = 2'd1;
            step.action     = ACT_SET_CW;
          end else begin
            step.next_phase = 2'd3;
            step.action     = ACT_SET_CCW;
          end
        end
      end
      2'd1: begin
        if (!line_sel && rising) begin
          step.next_phase = 2'd0;
          step.action     = ACT_DEC;
        end else if (line_sel && !rising) begin
          step.next_phase = 2'd2;
        end
      end
      2'd2: begin
        if (rising) begin
          step.next_phase = line_sel ? 2'd1 : 2'd3;
        end
      end
      2'd3: begin
        if (!line_sel && !rising) begin
          step.next_phase = 2'd2;
        end else if (line_sel && rising) begin
          step.next_phase = 2'd0;
          step.action     = ACT_INC;
        end
      end
      default: begin
        step.next_phase = phase;
      end
    endcase
  end

endmodule

/* rtl/qec_count.sv */
`timescale 1ns / 1ps
// Count update of the quadrature encoder counter: step add or subtract
// with clamping. Depends on qec_pkg.
module qec_count (
  input  qec_pkg::action_t   action,
  input  logic               direction,
  input  logic signed [15:0] count,
  input  logic [7:0]         step_size,
  input  logic [14:0]        min_count,
  input  logic [14:0]        max_count,
  output logic signed [15:0] count_next
);
  import qec_pkg::*;

  logic signed [17:0] count_ext;
  logic signed [17:0] step_ext;
  logic signed [17:0] min_ext;
  logic signed [17:0] max_ext;
  logic signed [17:0] dec_sum;
  logic signed [17:0] inc_sum;

  assign count_ext = {{2{count[15]}}, count};
  assign step_ext  = {10'd0, step_size};
  assign min_ext   = {3'd0, min_count};
  assign max_ext   = {3'd0, max_count};
  assign dec_sum   = count_ext - step_ext;
  assign inc_sum   = count_ext + step_ext;

  always_comb begin
    count_next = count;
    case (action)
      ACT_DEC: begin
        if (!direction) begin
          count_next = (dec_sum < min_ext) ? {1'b0, min_count} : dec_sum[15:0];
        end
      end
      ACT_INC: begin
        if (direction) begin
          count_next = (inc_sum > max_ext) ? {1'b0, max_count} : inc_sum[15:0];
        end
      end
      default: begin
        count_next = count;
      end
    endcase
  end

endmodule

/* rtl/quadrature_encoder_counter_top.sv */
`timescale 1ns / 1ps
// Quadrature encoder counter, top level. Depends on qec_pkg, qec_if,
// qec_decode and qec_count.
// An accepted input item is held in the input register, then moves to the result
// register once that register is empty or its item is being taken.
// Throughput: 1 item per cycle while the sink keeps taking results, set by the
// combinational phase table and count update on the state registers.
// Reset (rst, synchronous): phase 0, counter-clockwise, count 0,
// step_size 1, min_count 0, max_count 500, both stages empty.
module quadrature_encoder_counter_top (
  input  logic            clk,
  input  logic            rst,
  qec_in_if.sink          in_ch,
  qec_out_if.source       out_ch,
  qec_cfg_if.sink         cfg_ch
);
  import qec_pkg::*;

  // Configuration registers
  logic [7:0]  step_size;
  logic [14:0] min_count;
  logic [14:0] max_count;

  // Input register stage
  logic               s1_valid;
  logic               s1_op;
  logic               s1_line_sel;
  logic               s1_rising;
  logic signed [15:0] s1_load_value;

  // Decoder state
  phase_t             phase_reg;
  logic               direction;
  logic signed [15:0] count_reg;

  // Result register
  logic               res_valid;
  logic signed [15:0] res_count;
  phase_t             res_phase;

  // Next state
  phase_t             phase_next;
  logic               direction_next;
  logic signed [15:0] count_next;
  logic signed [15:0] step_count;
  qec_step_t          step;
  logic               advance;

  // Move the held item into the result register whenever that register is
  // empty or its item is being taken this cycle.
  assign advance     = s1_valid && (!res_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || advance;

  // Writes must only arrive while the block is idle; the block does not enforce this and takes them at once.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= STEP_SIZE_RESET;
      min_count <= MIN_COUNT_RESET;
      max_count <= MAX_COUNT_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_STEP_SIZE: step_size <= cfg_ch.data[7:0];
        REG_MIN_COUNT: min_count <= cfg_ch.data[14:0];
        REG_MAX_COUNT: max_count <= cfg_ch.data[14:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  // Input register: hold the item until it advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_op         <= in_ch.op;
      s1_line_sel   <= in_ch.line_sel;
      s1_rising     <= in_ch.rising;
      s1_load_value <= in_ch.load_value;
    end
  end

  qec_decode u_decode (
    .phase    (phase_reg),
    .line_sel (s1_line_sel),
    .rising   (s1_rising),
    .step     (step)
  );

  qec_count u_count (
    .action     (step.action),
    .direction  (direction),
    .count      (count_reg),
    .step_size  (step_size),
    .min_count  (min_count),
    .max_count  (max_count),
    .count_next (step_count)
  );

  // A load overwrites the count and leaves phase and direction alone; an
  // edge event follows the phase table.
  always_comb begin
    phase_next     = phase_reg;
    direction_next = direction;
    count_next     = count_reg;
    if (s1_op) begin
      count_next = s1_load_value;
    end else begin
      phase_next = step.next_phase;
      count_next = step_count;
      case (step.action)
        ACT_SET_CW:  direction_next = 1'b1;
        ACT_SET_CCW: direction_next = 1'b0;
        default:     direction_next = direction;
      endcase
    end
  end

  // Commit state only when the item advances into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg <= PHASE_RESET;
      direction <= 1'b0;
      count_reg <= '0;
    end else if (advance) begin
      phase_reg <= phase_next;
      direction <= direction_next;
      count_reg <= count_next;
    end
  end

  // Result register: hold the result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_count <= count_next;
      res_phase <= phase_next;
    end
  end

  assign out_ch.valid = res_valid;
  assign out_ch.count = res_count;
  assign out_ch.phase = res_phase;

endmodule

/* tb/sv/tb_quadrature_encoder_counter_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for quadrature_encoder_counter_top: drives edge and
// load items, predicts count and phase for each one and checks every result.
// Depends on qec_pkg, qec_if and the counter RTL.
module tb_quadrature_encoder_counter_top;
  import qec_pkg::*;

  // Field codes of an input item
  localparam logic OP_EDGE   = 1'b0;
  localparam logic OP_LOAD   = 1'b1;
  localparam logic LINE_A    = 1'b0;
  localparam logic LINE_B    = 1'b1;
  localparam logic EDGE_FALL = 1'b0;
  localparam logic EDGE_RISE = 1'b1;

  // Decoder phases, named after the line levels they stand for
  localparam phase_t PH_BOTH_HIGH = 2'd0;
  localparam phase_t PH_A_LOW     = 2'd1;
  localparam phase_t PH_BOTH_LOW  = 2'd2;
  localparam phase_t PH_B_LOW     = 2'd3;

  localparam int RESET_CYCLES  = 10;
  localparam int SETTLE_CYCLES = 4;     // two-stage pipe plus margin
  localparam int STALL_LIMIT   = 2000;  // cycles with no handshake at all
  localparam int SEGMENT_ITEMS = 225;
  localparam int NUM_SEGMENTS  = 8;

  typedef struct packed {
    logic               op;
    logic               line_sel;
    logic               rising;
    logic signed [15:0] load_value;
  } enc_item_t;

  typedef struct packed {
    logic signed [15:0] count;
    phase_t             phase;
  } reading_t;

  logic clk = 1'b0;
  logic rst;

  qec_in_if  in_ch ();
  qec_out_if out_ch ();
  qec_cfg_if cfg_ch ();

  quadrature_encoder_counter_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #2 clk = ~clk;

  // Predicted registers and decoder state
  logic [7:0]         cur_step;
  logic [14:0]        cur_min;
  logic [14:0]        cur_max;
  phase_t             dec_phase;
  logic               dec_cw;
  logic signed [15:0] dec_count;

  reading_t expected_readings[$];
  int       error_count = 0;
  int       items_sent  = 0;
  int       idle_cycles = 0;
  int       tx_idle_pct = 0;
  int       rx_stall_pct = 0;

  // Advance the predicted decoder by one item and return the reading it gives
  function automatic reading_t decode_item(enc_item_t it);
    phase_t  nxt;
    action_t act;
    int      sum;
    nxt = dec_phase;
    act = ACT_NONE;
    if (it.op == OP_LOAD) begin
      // load bypasses the clamps and leaves phase and direction alone
      dec_count = it.load_value;
    end else begin
      case (dec_phase)
        PH_BOTH_HIGH: begin
          if (it.rising == EDGE_FALL && it.line_sel == LINE_A) begin
            nxt = PH_A_LOW;
            act = ACT_SET_CW;
          end else if (it.rising == EDGE_FALL) begin
            nxt = PH_B_LOW;
            act = ACT_SET_CCW;
          end
        end
        PH_A_LOW: begin
          if (it.rising == EDGE_RISE && it.line_sel == LINE_A) begin
            nxt = PH_BOTH_HIGH;
            act = ACT_DEC;
          end else if (it.rising == EDGE_FALL && it.line_sel == LINE_B) begin
            nxt = PH_BOTH_LOW;
          end
        end
        PH_BOTH_LOW: begin
          if (it.rising == EDGE_RISE && it.line_sel == LINE_A) begin
            nxt = PH_B_LOW;
          end else if (it.rising == EDGE_RISE) begin
            nxt = PH_A_LOW;
          end
        end
        default: begin
          if (it.rising == EDGE_FALL && it.line_sel == LINE_A) begin
            nxt = PH_BOTH_LOW;
          end else if (it.rising == EDGE_RISE && it.line_sel == LINE_B) begin
            nxt = PH_BOTH_HIGH;
            act = ACT_INC;
          end
        end
      endcase
      case (act)
        ACT_SET_CW:  dec_cw = 1'b1;
        ACT_SET_CCW: dec_cw = 1'b0;
        ACT_DEC: begin
          // only a detent started counter-clockwise moves the count down
          if (!dec_cw) begin
            sum = int'(dec_count) - int'(cur_step);
            if (sum < int'(cur_min)) sum = int'(cur_min);
            dec_count = 16'(sum);
          end
        end
        ACT_INC: begin
          if (dec_cw) begin
            sum = int'(dec_count) + int'(cur_step);
            if (sum > int'(cur_max)) sum = int'(cur_max);
            dec_count = 16'(sum);
          end
        end
        default: ;
      endcase
      dec_phase = nxt;
    end
    return '{count: dec_count, phase: dec_phase};
  endfunction

  // Offer one item, with a random gap first, and log its reading on acceptance.
  // Valid stays high on exit so back-to-back items need no second assignment.
  task automatic send_item(enc_item_t it);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= it.op;
    in_ch.line_sel   <= it.line_sel;
    in_ch.rising     <= it.rising;
    in_ch.load_value <= it.load_value;
    do @(posedge clk); while (!in_ch.ready);
    expected_readings.push_back(decode_item(it));
    items_sent++;
  endtask

  task automatic send_edge(logic line, logic rise);
    // load_value is ignored on edges; randomise it anyway
    send_item('{op: OP_EDGE, line_sel: line, rising: rise, load_value: 16'($urandom)});
  endtask

  task automatic send_load(logic signed [15:0] value);
    send_item('{op: OP_LOAD, line_sel: 1'($urandom), rising: 1'($urandom),
                load_value: value});
  endtask

  // One full detent; a broken one has a single edge swapped for a random one
  task automatic send_detent(bit clockwise, bit broken);
    logic [1:0] seq [4];
    int         bad;
    if (clockwise) begin
      seq = '{{LINE_A, EDGE_FALL}, {LINE_B, EDGE_FALL}, {LINE_A, EDGE_RISE}, {LINE_B, EDGE_RISE}};
    end else begin
      seq = '{{LINE_B, EDGE_FALL}, {LINE_A, EDGE_FALL}, {LINE_B, EDGE_RISE}, {LINE_A, EDGE_RISE}};
    end
    bad = broken ? $urandom_range(3) : -1;
    for (int i = 0; i < 4; i++) begin
      if (i == bad) send_edge(1'($urandom), 1'($urandom));
      else send_edge(seq[i][1], seq[i][0]);
    end
  endtask

  // Drop valid and hold until every reading is back, then let the pipe settle
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(reg_index_t idx, logic [CfgDataWidth-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_STEP_SIZE: cur_step = value[7:0];
      REG_MIN_COUNT: cur_min  = value[14:0];
      REG_MAX_COUNT: cur_max  = value[14:0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Reprogram all three registers once the block is idle; the unused upper
  // data bits carry random junk that the block must ignore
  task automatic reconfigure(logic [7:0] step, logic [14:0] lo, logic [14:0] hi);
    drain_results();
    write_register(REG_STEP_SIZE, {8'($urandom), step});
    write_register(REG_MIN_COUNT, {1'($urandom), lo});
    write_register(REG_MAX_COUNT, {1'($urandom), hi});
  endtask

  // Load values weighted towards the range limits and the clamp edges
  function automatic logic signed [15:0] pick_load_value();
    case ($urandom_range(7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'(int'(cur_min) - 1);
      3:       return 16'(int'(cur_max) + 1);
      4:       return 16'(cur_min);
      5:       return 16'(cur_max);
      default: return 16'($urandom);
    endcase
  endfunction

  // Walk every entry of the phase table: a clockwise detent with every dead
  // edge on the way, then a counter-clockwise detent back down
  task automatic test_phase_table();
    send_edge(LINE_A, EDGE_RISE);
    send_edge(LINE_B, EDGE_RISE);
    send_edge(LINE_A, EDGE_FALL);
    send_edge(LINE_A, EDGE_FALL);
    send_edge(LINE_B, EDGE_RISE);
    send_edge(LINE_B, EDGE_FALL);
    send_edge(LINE_A, EDGE_FALL);
    send_edge(LINE_B, EDGE_FALL);
    send_edge(LINE_A, EDGE_RISE);
    send_edge(LINE_A, EDGE_RISE);
    send_edge(LINE_B, EDGE_FALL);
    send_edge(LINE_B, EDGE_RISE);
    send_detent(1'b0, 1'b0);
  endtask

  // Return to phase 0 through the closing edge of the other direction:
  // the count must stay put
  task automatic test_direction_mismatch();
    send_edge(LINE_A, EDGE_FALL);
    send_edge(LINE_A, EDGE_RISE);
    send_edge(LINE_B, EDGE_FALL);
    send_edge(LINE_B, EDGE_RISE);
  endtask

  // Loads at both ends of the range, then detents that must clamp: at
  // max before an increment, below min before a decrement
  task automatic test_loads_and_clamps();
    reconfigure(8'd255, 15'd100, 15'd32767);
    send_load(16'sh7fff);
    send_detent(1'b1, 1'b0);
    send_load(16'sh8000);
    send_detent(1'b0, 1'b0);
  endtask

  // Segments of mostly well-formed detents with random content, plus loads,
  // stray edges and broken detents; each segment is reconfigured and takes
  // one of four idling patterns
  task automatic test_random_traffic();
    int  seg_start;
    int  pick;
    bit  paused;
    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      case (seg)
        0:       reconfigure(STEP_SIZE_RESET, MIN_COUNT_RESET, MAX_COUNT_RESET);
        1:       reconfigure(8'd0, 15'd0, 15'd32767);
        2:       reconfigure(8'd255, 15'd32767, 15'd0);   // crossed bounds
        3:       reconfigure(8'd255, 15'd0, 15'd32767);
        default: reconfigure(8'($urandom), 15'($urandom), 15'($urandom));
      endcase
      case (seg % 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 68; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 68; end
        default: begin tx_idle_pct = 33; rx_stall_pct = 33; end
      endcase
      seg_start = items_sent;
      paused = 1'b0;
      while (items_sent - seg_start < SEGMENT_ITEMS) begin
        // hold the sender once mid-run until the block has emptied
        if (seg == 2 && !paused && items_sent - seg_start >= SEGMENT_ITEMS / 2) begin
          drain_results();
          paused = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 40) send_detent(1'b1, $urandom_range(9) == 0);
        else if (pick < 70) send_detent(1'b0, $urandom_range(9) == 0);
        else if (pick < 85) send_edge(1'($urandom), 1'($urandom));
        else send_load(pick_load_value());
      end
    end
    tx_idle_pct = 0;
    rx_stall_pct = 0;
  endtask

  // Receiver: stall at random, per cycle
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Compare every accepted result against the oldest prediction
  always @(posedge clk) begin
    reading_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected result count=%0d phase=%0d", $time,
                 out_ch.count, out_ch.phase);
        error_count++;
      end else begin
        want = expected_readings.pop_front();
        if (out_ch.count !== want.count) begin
          $display("%0t: count expected %0d actual %0d", $time, want.count, out_ch.count);
          error_count++;
        end
        if (out_ch.phase !== want.phase) begin
          $display("%0t: phase expected %0d actual %0d", $time, want.phase, out_ch.phase);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no channel moves an item for too long
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    // Drive every input to a known value and hold reset
    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_EDGE;
    in_ch.line_sel   = LINE_A;
    in_ch.rising     = EDGE_FALL;
    in_ch.load_value = '0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_STEP_SIZE;
    cfg_ch.data      = '0;
    cur_step  = STEP_SIZE_RESET;
    cur_min   = MIN_COUNT_RESET;
    cur_max   = MAX_COUNT_RESET;
    dec_phase = PHASE_RESET;
    dec_cw    = 1'b0;
    dec_count = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_phase_table();
    test_direction_mismatch();
    test_loads_and_clamps();
    test_random_traffic();

    drain_results();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
